### design/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants of the banked memory map with palette ports.
// ----------------------------------------------------------------------------
package bmm_pkg;

    localparam int PALETTE_BYTES = 64;
    localparam int WORK_BANKS    = 8;
    localparam int PAL_AW        = $clog2(PALETTE_BYTES);
    localparam int BYTE_W        = 8;

    localparam logic MODE_WRITE = 1'b1;

    localparam logic [2:0] REG_BOOT    = 3'd0;
    localparam logic [2:0] REG_CART    = 3'd1;
    localparam logic [2:0] REG_VRAM0   = 3'd2;
    localparam logic [2:0] REG_VRAM1   = 3'd3;
    localparam logic [2:0] REG_WRAM    = 3'd4;
    localparam logic [2:0] REG_GENERAL = 3'd5;
    localparam logic [2:0] REG_INSIDE  = 3'd6;

    localparam logic [15:0] ADDR_JOYP = 16'hFF00;
    localparam logic [15:0] ADDR_VBK  = 16'hFF4F;
    localparam logic [15:0] ADDR_BOOT = 16'hFF50;
    localparam logic [15:0] ADDR_BGPI = 16'hFF68;
    localparam logic [15:0] ADDR_BGPD = 16'hFF69;
    localparam logic [15:0] ADDR_OBPI = 16'hFF6A;
    localparam logic [15:0] ADDR_OBPD = 16'hFF6B;
    localparam logic [15:0] ADDR_SVBK = 16'hFF70;

    localparam logic [15:0] BOOT_LAST  = 16'h00FF;
    localparam logic [15:0] BASE_VRAM  = 16'h8000;
    localparam logic [15:0] BASE_WRAM0 = 16'hC000;
    localparam logic [15:0] BASE_WRAM1 = 16'hD000;
    localparam logic [15:0] BASE_ECHO  = 16'hE000;
    localparam logic [15:0] LAST_ECHO  = 16'hFDFF;
    localparam logic [15:0] ECHO_SPAN  = 16'h2000;
    localparam logic [15:0] VRAM_SPAN  = 16'h2000;
    localparam logic [15:0] WRAM_BANK  = 16'h1000;

    localparam logic [7:0] JOYP_LOW_SET = 8'h0F;

    typedef enum logic [1:0] {
        RD_FIXED = 2'd0,
        RD_BG    = 2'd1,
        RD_OBJ   = 2'd2
    } t_rd_src;

    typedef struct packed {
        logic        mode;
        logic [15:0] address;
        logic [7:0]  write_byte;
        logic [7:0]  buttons;
    } t_req;

    typedef struct packed {
        logic [2:0]  region;
        logic [15:0] offset;
        logic [7:0]  read_byte;
        logic [7:0]  store_byte;
    } t_rsp;

    typedef struct packed {
        logic [2:0]  region;
        logic [15:0] offset;
        logic [7:0]  store_byte;
        t_rd_src     rd_src;
        logic [7:0]  rd_fixed;
        logic        pal_ok;
    } t_stage;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [PAL_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_pal_port;

endpackage

### design/bmm_req_if.sv
// ----------------------------------------------------------------------------
// bmm_req_if
// Bus access channel: valid, ready and one access.
// ----------------------------------------------------------------------------
interface bmm_req_if;
    import bmm_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### design/bmm_rsp_if.sv
// ----------------------------------------------------------------------------
// bmm_rsp_if
// Result channel: valid, ready and one decoded result.
// ----------------------------------------------------------------------------
interface bmm_rsp_if;
    import bmm_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### design/bmm_ram.sv
// ----------------------------------------------------------------------------
// bmm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/bmm_ctrl.sv
// ----------------------------------------------------------------------------
// bmm_ctrl
// Address decode, bank and select registers, palette index ports.
// ----------------------------------------------------------------------------
module bmm_ctrl #(
    parameter int WORK_BANKS = bmm_pkg::WORK_BANKS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  bmm_pkg::t_req      i_req,
    output bmm_pkg::t_stage    o_stage,
    output bmm_pkg::t_pal_port o_bg,
    output bmm_pkg::t_pal_port o_obj
);
    import bmm_pkg::*;

    logic              r_video_bank, n_video_bank;
    logic [2:0]        r_work_bank,  n_work_bank;
    logic              r_boot_mapped, n_boot_mapped;
    logic [PAL_AW-1:0] r_bg_idx,  n_bg_idx;
    logic              r_bg_inc,  n_bg_inc;
    logic [PAL_AW-1:0] r_obj_idx, n_obj_idx;
    logic              r_obj_inc, n_obj_inc;
    logic [7:0]        r_pad_sel, n_pad_sel;
    logic [PALETTE_BYTES-1:0] r_bg_vld, n_bg_vld;
    logic [PALETTE_BYTES-1:0] r_obj_vld, n_obj_vld;

    logic        is_wr;
    logic [15:0] a;
    logic [15:0] am;
    logic [7:0]  wb;
    logic [3:0]  keys;
    logic        bg_wr, obj_wr;

    always_comb begin
        is_wr = (i_req.mode == MODE_WRITE);
        a     = i_req.address;
        wb    = i_req.write_byte;

        if (a >= BASE_ECHO && a <= LAST_ECHO) begin
            am = a - ECHO_SPAN;
        end else begin
            am = a;
        end

        keys = 4'hF;
        if (!r_pad_sel[5]) begin
            keys = 4'hF ^ i_req.buttons[3:0];
        end else if (!r_pad_sel[4]) begin
            keys = 4'hF ^ i_req.buttons[7:4];
        end

        o_stage.store_byte = is_wr ? wb : 8'h00;
        o_stage.rd_src     = RD_FIXED;
        o_stage.rd_fixed   = 8'h00;
        o_stage.pal_ok     = 1'b0;

        priority if (am <= BOOT_LAST) begin
            o_stage.region = r_boot_mapped ? REG_BOOT : REG_CART;
            o_stage.offset = am;
        end else if (am >= BASE_VRAM && am < BASE_VRAM + VRAM_SPAN) begin
            o_stage.region = r_video_bank ? REG_VRAM1 : REG_VRAM0;
            o_stage.offset = am - BASE_VRAM;
        end else if (am >= BASE_WRAM0 && am < BASE_WRAM1) begin
            o_stage.region = REG_WRAM;
            o_stage.offset = am - BASE_WRAM0;
        end else if (am >= BASE_WRAM1 && am < BASE_WRAM1 + WRAM_BANK) begin
            o_stage.region = REG_WRAM;
            o_stage.offset = {1'b0, r_work_bank, am[11:0]};
        end else begin
            o_stage.region = REG_GENERAL;
            o_stage.offset = am;
        end

        n_video_bank  = r_video_bank;
        n_work_bank   = r_work_bank;
        n_boot_mapped = r_boot_mapped;
        n_bg_idx      = r_bg_idx;
        n_bg_inc      = r_bg_inc;
        n_obj_idx     = r_obj_idx;
        n_obj_inc     = r_obj_inc;
        n_pad_sel     = r_pad_sel;
        n_bg_vld      = r_bg_vld;
        n_obj_vld     = r_obj_vld;
        bg_wr         = 1'b0;
        obj_wr        = 1'b0;

        if (!is_wr) begin
            unique case (a)
                ADDR_JOYP: begin
                    o_stage.region   = REG_INSIDE;
                    o_stage.rd_fixed = {r_pad_sel[7:4], keys};
                end
                ADDR_BGPD: begin
                    o_stage.region = REG_INSIDE;
                    o_stage.rd_src = RD_BG;
                    o_stage.pal_ok = r_bg_vld[r_bg_idx];
                end
                ADDR_OBPD: begin
                    o_stage.region = REG_INSIDE;
                    o_stage.rd_src = RD_OBJ;
                    o_stage.pal_ok = r_obj_vld[r_obj_idx];
                end
                default: begin
                end
            endcase
        end else begin
            unique case (a)
                ADDR_JOYP: begin
                    n_pad_sel          = wb | JOYP_LOW_SET;
                    o_stage.store_byte = wb | JOYP_LOW_SET;
                end
                ADDR_VBK: begin
                    n_video_bank = wb[0];
                end
                ADDR_BOOT: begin
                    n_boot_mapped = 1'b0;
                end
                ADDR_BGPI: begin
                    n_bg_idx = wb[PAL_AW-1:0];
                    n_bg_inc = wb[7];
                end
                ADDR_BGPD: begin
                    o_stage.region     = REG_INSIDE;
                    bg_wr              = 1'b1;
                    n_bg_vld[r_bg_idx] = 1'b1;
                    if (r_bg_inc) begin
                        n_bg_idx = r_bg_idx + 1'b1;
                    end
                end
                ADDR_OBPI: begin
                    n_obj_idx = wb[PAL_AW-1:0];
                    n_obj_inc = wb[7];
                end
                ADDR_OBPD: begin
                    o_stage.region       = REG_INSIDE;
                    obj_wr               = 1'b1;
                    n_obj_vld[r_obj_idx] = 1'b1;
                    if (r_obj_inc) begin
                        n_obj_idx = r_obj_idx + 1'b1;
                    end
                end
                ADDR_SVBK: begin
                    if (wb == 8'h00) begin
                        n_work_bank = 3'd1;
                    end else if (wb < 8'(WORK_BANKS)) begin
                        n_work_bank = wb[2:0];
                    end
                end
                default: begin
                end
            endcase
        end

        o_bg.we    = i_acc && bg_wr;
        o_bg.re    = i_acc && !is_wr && (a == ADDR_BGPD);
        o_bg.addr  = r_bg_idx;
        o_bg.wdata = wb;
        o_obj.we    = i_acc && obj_wr;
        o_obj.re    = i_acc && !is_wr && (a == ADDR_OBPD);
        o_obj.addr  = r_obj_idx;
        o_obj.wdata = wb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_bank  <= 1'b0;
            r_work_bank   <= 3'd1;
            r_boot_mapped <= 1'b1;
            r_bg_idx      <= '0;
            r_bg_inc      <= 1'b0;
            r_obj_idx     <= '0;
            r_obj_inc     <= 1'b0;
            r_pad_sel     <= 8'hFF;
            r_bg_vld      <= '0;
            r_obj_vld     <= '0;
        end else if (i_acc) begin
            r_video_bank  <= n_video_bank;
            r_work_bank   <= n_work_bank;
            r_boot_mapped <= n_boot_mapped;
            r_bg_idx      <= n_bg_idx;
            r_bg_inc      <= n_bg_inc;
            r_obj_idx     <= n_obj_idx;
            r_obj_inc     <= n_obj_inc;
            r_pad_sel     <= n_pad_sel;
            r_bg_vld      <= n_bg_vld;
            r_obj_vld     <= n_obj_vld;
        end
    end
endmodule

### design/banked_memory_map_with_palette_ports.sv
// ----------------------------------------------------------------------------
// banked_memory_map_with_palette_ports
// Bus address decoder with bank registers, two palette memories and joypad.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | transfer
//  ---------+-----+------------------------------------------+----------------
//  i_req    | in  | mode, address, write_byte, buttons       | valid & ready
//  o_rsp    | out | region, offset, read_byte, store_byte    | valid & ready
//
//  One transfer per cycle sustained while o_rsp is ready; each result passes
//  through the stage register and then the result register.
//  The palette memories read through a registered port, which sets the depth.
//  Reset is synchronous, active low; palette entries read as zero until written.
//  A stall on o_rsp backs up through the stage register into i_req.ready.
// ----------------------------------------------------------------------------
module banked_memory_map_with_palette_ports #(
    parameter int WORK_BANKS = bmm_pkg::WORK_BANKS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmm_req_if.sink   i_req,
    bmm_rsp_if.source o_rsp
);
    import bmm_pkg::*;

    t_stage    s0;
    t_pal_port bg_port;
    t_pal_port obj_port;
    logic [7:0] bg_q;
    logic [7:0] obj_q;

    logic   r_s1_vld, n_s1_vld;
    t_stage r_s1;
    logic   r_out_vld, n_out_vld;
    t_rsp   r_out;
    t_rsp   n_out;

    logic acc;
    logic out_free;
    logic s1_adv;

    assign out_free    = !r_out_vld || o_rsp.ready;
    assign s1_adv      = r_s1_vld && out_free;
    assign i_req.ready = !r_s1_vld || out_free;
    assign acc         = i_req.valid && i_req.ready;

    bmm_ctrl #(
        .WORK_BANKS (WORK_BANKS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_req   (i_req.data),
        .o_stage (s0),
        .o_bg    (bg_port),
        .o_obj   (obj_port)
    );

    bmm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PALETTE_BYTES)
    ) u_bg_ram (
        .i_clk   (i_clk),
        .i_we    (bg_port.we),
        .i_waddr (bg_port.addr),
        .i_wdata (bg_port.wdata),
        .i_re    (bg_port.re),
        .i_raddr (bg_port.addr),
        .o_rdata (bg_q)
    );

    bmm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PALETTE_BYTES)
    ) u_obj_ram (
        .i_clk   (i_clk),
        .i_we    (obj_port.we),
        .i_waddr (obj_port.addr),
        .i_wdata (obj_port.wdata),
        .i_re    (obj_port.re),
        .i_raddr (obj_port.addr),
        .o_rdata (obj_q)
    );

    always_comb begin
        n_s1_vld  = acc || (r_s1_vld && !out_free);
        n_out_vld = s1_adv || (r_out_vld && !o_rsp.ready);

        n_out.region     = r_s1.region;
        n_out.offset     = r_s1.offset;
        n_out.store_byte = r_s1.store_byte;
        unique case (r_s1.rd_src)
            RD_BG:   n_out.read_byte = r_s1.pal_ok ? bg_q : 8'h00;
            RD_OBJ:  n_out.read_byte = r_s1.pal_ok ? obj_q : 8'h00;
            default: n_out.read_byte = r_s1.rd_fixed;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= s0;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;
endmodule

### sim/banked_memory_map_with_palette_ports_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_memory_map_with_palette_ports_test
// Self-checking bench for the bus decoder with palette ports and joypad.
// A table of directed accesses covers reset values, decode boundaries, echo
// mirroring, bank selects, palette auto-increment and the joypad groups.
// Random bus traffic and palette bursts follow. Every transfer is predicted
// by an in-bench model of the decoder state. Both channels idle at random,
// apart from one steady stretch, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module banked_memory_map_with_palette_ports_test;
    import bmm_pkg::*;

    localparam logic MODE_READ    = ~MODE_WRITE;
    localparam int   RANDOM_ITEMS = 1050;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   PLAN_ROWS    = 29;
    localparam int   PORT_COUNT   = 9;

    typedef struct packed {
        logic typed;
        t_rsp want;
    } t_note;

    typedef struct packed {
        t_req  acc;
        t_note note;
    } t_row;

    localparam t_row PLAN [PLAN_ROWS] = '{
        '{'{MODE_READ,  16'h0000, 8'h00, 8'h00}, '{1'b1, '{REG_BOOT,    16'h0000, 8'h00, 8'h00}}},
        '{'{MODE_READ,  ADDR_JOYP, 8'h00, 8'hFF}, '{1'b1, '{REG_INSIDE, ADDR_JOYP, 8'hFF, 8'h00}}},
        '{'{MODE_READ,  ADDR_BGPD, 8'h00, 8'h00}, '{1'b1, '{REG_INSIDE, ADDR_BGPD, 8'h00, 8'h00}}},
        '{'{MODE_READ,  16'h8000, 8'h00, 8'h00}, '{1'b1, '{REG_VRAM0,   16'h0000, 8'h00, 8'h00}}},
        '{'{MODE_READ,  16'hD000, 8'h00, 8'h00}, '{1'b1, '{REG_WRAM,    16'h1000, 8'h00, 8'h00}}},
        '{'{MODE_READ,  16'hE000, 8'h00, 8'h00}, '{1'b1, '{REG_WRAM,    16'h0000, 8'h00, 8'h00}}},
        '{'{MODE_WRITE, 16'hFDFF, 8'hFF, 8'h00}, '{1'b1, '{REG_WRAM,    16'h1DFF, 8'h00, 8'hFF}}},
        '{'{MODE_READ,  16'hFFFF, 8'h00, 8'h00}, '{1'b1, '{REG_GENERAL, 16'hFFFF, 8'h00, 8'h00}}},
        '{'{MODE_WRITE, ADDR_BGPI, 8'hBE, 8'h00}, '0},
        '{'{MODE_WRITE, ADDR_BGPD, 8'h11, 8'h00}, '0},
        '{'{MODE_WRITE, ADDR_BGPD, 8'h22, 8'h00}, '0},
        '{'{MODE_WRITE, ADDR_BGPI, 8'h3E, 8'h00}, '0},
        '{'{MODE_READ,  ADDR_BGPD, 8'h00, 8'h00}, '0},
        '{'{MODE_WRITE, ADDR_OBPI, 8'hFF, 8'h00}, '0},
        '{'{MODE_WRITE, ADDR_OBPD, 8'hA5, 8'h00}, '0},
        '{'{MODE_READ,  ADDR_OBPD, 8'h00, 8'h00}, '0},
        '{'{MODE_WRITE, ADDR_VBK,  8'h01, 8'h00}, '{1'b1, '{REG_GENERAL, ADDR_VBK, 8'h00, 8'h01}}},
        '{'{MODE_READ,  16'h9FFF, 8'h00, 8'h00}, '0},
        '{'{MODE_WRITE, ADDR_SVBK, 8'h00, 8'h00}, '0},
        '{'{MODE_WRITE, ADDR_SVBK, 8'h08, 8'h00}, '0},
        '{'{MODE_READ,  16'hDFFF, 8'h00, 8'h00}, '0},
        '{'{MODE_WRITE, ADDR_JOYP, 8'h00, 8'h00}, '{1'b1, '{REG_GENERAL, ADDR_JOYP, 8'h00, 8'h0F}}},
        '{'{MODE_READ,  ADDR_JOYP, 8'h00, 8'h5A}, '0},
        '{'{MODE_WRITE, ADDR_JOYP, 8'h20, 8'h00}, '0},
        '{'{MODE_READ,  ADDR_JOYP, 8'h00, 8'hA5}, '0},
        '{'{MODE_WRITE, ADDR_JOYP, 8'h30, 8'h00}, '0},
        '{'{MODE_READ,  ADDR_JOYP, 8'h00, 8'h3C}, '{1'b1, '{REG_INSIDE, ADDR_JOYP, 8'h3F, 8'h00}}},
        '{'{MODE_WRITE, ADDR_BOOT, 8'h00, 8'h00}, '{1'b1, '{REG_GENERAL, ADDR_BOOT, 8'h00, 8'h00}}},
        '{'{MODE_READ,  16'h00FF, 8'h00, 8'h00}, '{1'b1, '{REG_CART,   16'h00FF, 8'h00, 8'h00}}}
    };

    localparam logic [15:0] PORTS [PORT_COUNT] = '{
        ADDR_JOYP, ADDR_VBK, ADDR_BOOT, ADDR_BGPI, ADDR_BGPD,
        ADDR_OBPI, ADDR_OBPD, ADDR_SVBK, ADDR_BGPD
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmm_req_if req_ch ();
    bmm_rsp_if rsp_ch ();

    banked_memory_map_with_palette_ports u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // decoder state as the bench sees it
    logic       vid_bank;
    logic [2:0] wram_bank;
    logic       boot_on;
    logic [5:0] bg_idx;
    logic       bg_inc;
    logic [5:0] obj_idx;
    logic       obj_inc;
    logic [7:0] bg_pal  [PALETTE_BYTES];
    logic [7:0] obj_pal [PALETTE_BYTES];
    logic [7:0] joy_sel;

    t_note offer_notes [$];
    t_rsp  pending_rsp [$];

    int  errors;
    int  sent;
    int  checked;
    int  inside_hits;
    int  wram_hits;
    int  cycles;
    bit  steady;
    bit  hold_off;

    initial begin
        vid_bank  = 1'b0;
        wram_bank = 3'd1;
        boot_on   = 1'b1;
        bg_idx    = '0;
        bg_inc    = 1'b0;
        obj_idx   = '0;
        obj_inc   = 1'b0;
        joy_sel   = 8'hFF;
        for (int n = 0; n < PALETTE_BYTES; n++) begin
            bg_pal[n]  = '0;
            obj_pal[n] = '0;
        end
    end

    function automatic t_rsp decode_access(input t_req acc);
        logic [15:0] a;
        logic [3:0]  keys;
        t_rsp        r;
        a = acc.address;
        r = '0;
        if (a >= BASE_ECHO && a <= LAST_ECHO) begin
            a = a - ECHO_SPAN;
        end
        r.offset = a;
        if (a <= BOOT_LAST) begin
            r.region = boot_on ? REG_BOOT : REG_CART;
        end else if (a >= BASE_VRAM && a < BASE_VRAM + VRAM_SPAN) begin
            r.region = vid_bank ? REG_VRAM1 : REG_VRAM0;
            r.offset = a - BASE_VRAM;
        end else if (a >= BASE_WRAM0 && a < BASE_WRAM1) begin
            r.region = REG_WRAM;
            r.offset = a - BASE_WRAM0;
        end else if (a >= BASE_WRAM1 && a < BASE_ECHO) begin
            r.region = REG_WRAM;
            r.offset = {1'b0, wram_bank, a[11:0]};
        end else begin
            r.region = REG_GENERAL;
        end

        if (acc.mode != MODE_WRITE) begin
            case (acc.address)
                ADDR_JOYP: begin
                    keys = 4'hF;
                    if (!joy_sel[5]) begin
                        keys ^= acc.buttons[3:0];
                    end else if (!joy_sel[4]) begin
                        keys ^= acc.buttons[7:4];
                    end
                    r.region    = REG_INSIDE;
                    r.read_byte = {joy_sel[7:4], keys};
                end
                ADDR_BGPD: begin
                    r.region    = REG_INSIDE;
                    r.read_byte = bg_pal[bg_idx];
                end
                ADDR_OBPD: begin
                    r.region    = REG_INSIDE;
                    r.read_byte = obj_pal[obj_idx];
                end
                default: ;
            endcase
        end else begin
            r.store_byte = acc.write_byte;
            case (acc.address)
                ADDR_JOYP: begin
                    joy_sel      = acc.write_byte | JOYP_LOW_SET;
                    r.store_byte = joy_sel;
                end
                ADDR_VBK:  vid_bank = acc.write_byte[0];
                ADDR_BOOT: boot_on = 1'b0;
                ADDR_BGPI: begin
                    bg_idx = acc.write_byte[5:0];
                    bg_inc = acc.write_byte[7];
                end
                ADDR_BGPD: begin
                    r.region       = REG_INSIDE;
                    bg_pal[bg_idx] = acc.write_byte;
                    if (bg_inc) begin
                        bg_idx = bg_idx + 6'd1;
                    end
                end
                ADDR_OBPI: begin
                    obj_idx = acc.write_byte[5:0];
                    obj_inc = acc.write_byte[7];
                end
                ADDR_OBPD: begin
                    r.region         = REG_INSIDE;
                    obj_pal[obj_idx] = acc.write_byte;
                    if (obj_inc) begin
                        obj_idx = obj_idx + 6'd1;
                    end
                end
                ADDR_SVBK: begin
                    if (acc.write_byte == 8'd0) begin
                        wram_bank = 3'd1;
                    end else if (acc.write_byte < WORK_BANKS) begin
                        wram_bank = acc.write_byte[2:0];
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %0s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_note note;
        t_rsp  got;
        t_rsp  want;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            note = offer_notes.pop_front();
            want = decode_access(req_ch.data);
            pending_rsp.push_back(note.typed ? note.want : want);
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (pending_rsp.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(got), 64'(0));
            end else begin
                want = pending_rsp.pop_front();
                if (got.region != want.region) begin
                    report_mismatch("region", 64'(got.region), 64'(want.region));
                end
                if (got.offset != want.offset) begin
                    report_mismatch("offset", 64'(got.offset), 64'(want.offset));
                end
                if (got.read_byte != want.read_byte) begin
                    report_mismatch("read_byte", 64'(got.read_byte), 64'(want.read_byte));
                end
                if (got.store_byte != want.store_byte) begin
                    report_mismatch("store_byte", 64'(got.store_byte),
                                    64'(want.store_byte));
                end
                checked++;
                if (want.region == REG_INSIDE) begin
                    inside_hits++;
                end
                if (want.region == REG_WRAM) begin
                    wram_hits++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d results pending", $realtime, pending_rsp.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random back-pressure plus one long hold-off
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                rsp_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge i_clk);
                end
                hold_off = 1'b0;
            end else begin
                rsp_ch.ready <= steady || ($urandom_range(99) >= 15);
            end
        end
    end

    task automatic send_access(input t_req acc, input t_note note);
        while (!steady && $urandom_range(99) < 15) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        offer_notes.push_back(note);
        req_ch.valid <= 1'b1;
        req_ch.data  <= acc;
        do @(posedge i_clk); while (!req_ch.ready);
        sent++;
    endtask

    initial begin
        t_req acc;
        int   pick;
        int   burst_len;
        bit   use_bg;
        bit   hold_done;
        sent      = 0;
        hold_done = 1'b0;
        steady    = 1'b0;
        hold_off  = 1'b0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            send_access(PLAN[i].acc, PLAN[i].note);
        end

        while (sent < PLAN_ROWS + RANDOM_ITEMS) begin
            steady = (sent >= 300 && sent < 500);
            if (sent >= 700 && !hold_done) begin
                hold_off  = 1'b1;
                hold_done = 1'b1;
            end
            acc.mode       = 1'($urandom_range(1));
            acc.write_byte = 8'($urandom);
            acc.buttons    = 8'($urandom);
            if ($urandom_range(9) < 3) begin
                // palette burst: set index, then stream data transfers
                use_bg      = 1'($urandom_range(1));
                acc.mode    = MODE_WRITE;
                acc.address = use_bg ? ADDR_BGPI : ADDR_OBPI;
                send_access(acc, '0);
                burst_len = $urandom_range(8, 1);
                for (int k = 0; k < burst_len; k++) begin
                    acc.mode       = 1'($urandom_range(1));
                    acc.address    = use_bg ? ADDR_BGPD : ADDR_OBPD;
                    acc.write_byte = 8'($urandom);
                    acc.buttons    = 8'($urandom);
                    send_access(acc, '0);
                end
            end else begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    acc.address = PORTS[$urandom_range(PORT_COUNT - 1)];
                    if (acc.address == ADDR_SVBK && $urandom_range(3) != 0) begin
                        acc.write_byte = 8'($urandom_range(9));
                    end
                end else if (pick < 45) begin
                    acc.address = 16'($urandom_range(BOOT_LAST));
                end else if (pick < 55) begin
                    acc.address = BASE_VRAM + 16'($urandom_range(VRAM_SPAN - 1));
                end else if (pick < 75) begin
                    acc.address = BASE_WRAM0 + 16'($urandom_range(2 * WRAM_BANK - 1));
                end else if (pick < 85) begin
                    acc.address = 16'($urandom_range(LAST_ECHO, BASE_ECHO));
                end else begin
                    acc.address = 16'($urandom);
                end
                send_access(acc, '0);
            end
        end
        steady = 1'b0;
        req_ch.valid <= 1'b0;

        while (checked < sent) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("Covered %0d bus transfers, %0d results checked, %0d served inside,",
                 sent, checked, inside_hits);
        $display("%0d work ram decodes, one long output stall of %0d cycles.",
                 wram_hits, HOLD_CYCLES);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
design/bmm_pkg.sv
design/bmm_req_if.sv
design/bmm_rsp_if.sv
design/bmm_ram.sv
design/bmm_ctrl.sv
design/banked_memory_map_with_palette_ports.sv
sim/banked_memory_map_with_palette_ports_test.sv
